// ===== hw/rtl/mpo_pkg.sv =====
// Package for the multiwave phase oscillator: field widths, codes, the
// controller state type, the command bundle and the quarter-sine table generator.
// No dependencies.
`default_nettype none

package mpo_pkg;

  localparam int DEF_TABLE_BITS = 10;
  localparam int DEF_PHASE_BITS = 32;

  localparam int FREQ_W     = 19;
  localparam int SAMPLE_W   = 16;
  localparam int RATE_W     = 18;
  localparam int WAVE_W     = 2;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 1;
  localparam int ROM_W      = 15;
  localparam int MAG_W      = 16;
  localparam int PROD_W     = 32;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'b1;

  // Waveform codes
  localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAW    = 2'd2;

  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

  // Gain of 0.8 in Q16, and the rounding offset applied with it
  localparam logic [MAG_W-1:0]  GAIN_Q16   = 16'd52429;
  localparam logic [PROD_W-1:0] GAIN_ROUND = 32'd32768;

  localparam logic [MAG_W-1:0] FULL_SCALE = 16'd32767;
  localparam logic [MAG_W-1:0] HALF_CODE  = 16'h8000;

  // Taylor series constants for building the sine table
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_FINISH
  } mpo_state_t;

  typedef struct packed {
    logic load;    // take the frequency, clear the divider
    logic step;    // one restoring division step
    logic finish;  // advance the phase, load the output register
  } mpo_cmd_t;

  // Quarter-wave entry: round(32767 * sin(pi/2 * (2i+1) / 2^(tbits+1)))
  // from a Q30 Taylor series, clamped to [0, 32767]. Elaboration only.
  function automatic logic [ROM_W-1:0] sine_entry(input int unsigned idx,
                                                  input int unsigned tbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    int                 k;
    x    = (HALF_PI_Q30 * (64'(idx) * 64'd2 + 64'd1)) >> (tbits + 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if ((k & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v[ROM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/multiwave_phase_oscillator.sv =====
// Top level of the multiwave phase oscillator: ports, controller and datapath.
// Depends on mpo_pkg, mpo_controller and mpo_datapath.
`default_nettype none

// Direct digital synthesis oscillator, one input beat per audio sample. Each
// beat carries the frequency in 1/16 Hz; the block answers with one signed
// 16-bit sample taken from the phase as it stood when the beat arrived, then
// advances the phase by floor(frequency * 2^PHASE_BITS / (16 * sample_rate)),
// wrapping modulo 2^PHASE_BITS. Waveforms are sine (quarter-wave table,
// mirrored per quadrant), square (positive in the first half cycle) and
// sawtooth, all scaled by 0.8 with the magnitude rounded half up; the unused
// wave code gives zero while the phase still advances, and a zero sample rate
// holds the phase. The phase increment comes from a bit-serial restoring
// divider, one quotient bit per clock over PHASE_BITS + 15 steps. When the
// division is done, the sample is loaded into the output register in the
// same step as the phase advance, and only after that is the next beat
// taken; one beat is in work at a time. The result waits
// in an output register, so the next beat can be taken while the previous
// sample is still unclaimed; a second finished sample holds until the first
// is taken. The sine table is a fixed ROM with registered read and
// needs no fill after reset. Configuration writes are taken in any cycle but
// must only be issued while the block is idle; register 0 selects the
// waveform, register 1 sets the sample rate in hertz (reset 48000).

module multiwave_phase_oscillator
  import mpo_pkg::*;
#(
  parameter int TABLE_BITS = DEF_TABLE_BITS,
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // sample tick with frequency
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FREQ_W-1:0]     frequency_q4,
  // sample result
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  mpo_cmd_t cmd;

  // Configuration registers accept a write in every cycle
  assign cfg_ready = 1'b1;

  mpo_controller #(
    .PHASE_BITS (PHASE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mpo_datapath #(
    .TABLE_BITS (TABLE_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frequency_q4 (frequency_q4),
    .sample_out   (sample_out)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mpo_controller.sv =====
// Sequencer of the multiwave phase oscillator: input handshake, divide-step
// count and output valid. Drives the datapath through mpo_cmd_t. Uses mpo_pkg.
`default_nettype none

module mpo_controller
  import mpo_pkg::*;
#(
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output mpo_cmd_t      cmd
);

  // One quotient bit per dividend bit: frequency bits plus shifted-in zeros
  localparam int DivSteps = PHASE_BITS + FREQ_W - 4;
  localparam int CntW     = $clog2(DivSteps);
  localparam logic [CntW-1:0] LastStep = CntW'(DivSteps - 1);

  mpo_state_t      state, state_next;
  logic [CntW-1:0] count, count_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          count_next = '0;
          state_next = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        cmd.step   = 1'b1;
        count_next = count + 1'b1;
        if (count == LastStep) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the output register to be free
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mpo_datapath.sv =====
// Datapath of the multiwave phase oscillator: configuration registers, phase
// accumulator, quarter-sine ROM, gain multiplier and serial divider. Uses mpo_pkg.
`default_nettype none

module mpo_datapath
  import mpo_pkg::*;
#(
  parameter int TABLE_BITS = DEF_TABLE_BITS,
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mpo_cmd_t              cmd,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [FREQ_W-1:0]     frequency_q4,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  localparam int TableSize = 1 << TABLE_BITS;

  logic [WAVE_W-1:0]     wave_select;
  logic [RATE_W-1:0]     sample_rate;
  logic [PHASE_BITS-1:0] phase;

  // Quarter-sine table, folded to constants at elaboration
  logic [ROM_W-1:0] sine_rom [TableSize];

  for (genvar g = 0; g < TableSize; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, TABLE_BITS);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_select <= WAVE_SINE;
      sample_rate <= RATE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WAVE_SELECT: wave_select <= cfg_data[WAVE_W-1:0];
        CFG_SAMPLE_RATE: sample_rate <= cfg_data[RATE_W-1:0];
        default:         wave_select <= wave_select;
      endcase
    end
  end

  // Waveform pipeline: ROM read, then magnitude times gain
  logic [1:0]            quad;
  logic [TABLE_BITS-1:0] tab_idx;
  logic [TABLE_BITS-1:0] rom_idx;
  logic [ROM_W-1:0]      rom_q;
  logic [SAMPLE_W-1:0]   saw_top;
  logic [MAG_W-1:0]      mag;
  logic                  neg;
  logic [PROD_W-1:0]     prod_q;
  logic                  neg_q;

  assign quad    = phase[PHASE_BITS-1 -: 2];
  assign tab_idx = phase[PHASE_BITS-3 -: TABLE_BITS];
  assign rom_idx = quad[0] ? ~tab_idx : tab_idx;
  assign saw_top = phase[PHASE_BITS-1 -: SAMPLE_W];

  always_comb begin
    mag = '0;
    neg = 1'b0;
    unique case (wave_select)
      WAVE_SINE: begin
        mag = {1'b0, rom_q};
        neg = quad[1];
      end
      WAVE_SQUARE: begin
        mag = FULL_SCALE;
        neg = phase[PHASE_BITS-1];
      end
      WAVE_SAW: begin
        if (saw_top[SAMPLE_W-1]) begin
          mag = {1'b0, saw_top[SAMPLE_W-2:0]};
          neg = 1'b0;
        end else begin
          mag = HALF_CODE - saw_top;
          neg = 1'b1;
        end
      end
      default: begin
        mag = '0;
        neg = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rom_q  <= sine_rom[rom_idx];
    prod_q <= mag * GAIN_Q16 + GAIN_ROUND;
    neg_q  <= neg;
  end

  logic [SAMPLE_W-1:0] scaled;
  assign scaled = prod_q[PROD_W-1 -: SAMPLE_W];

  // Restoring divider: (frequency << (PHASE_BITS-4)) / sample_rate
  logic [FREQ_W-1:0]     div_sh;
  logic [RATE_W-1:0]     rem;
  logic [PHASE_BITS-1:0] quo;
  logic [RATE_W:0]       trial;
  logic [RATE_W:0]       diff;
  logic                  ge;

  assign trial = {rem, div_sh[FREQ_W-1]};
  assign diff  = trial - {1'b0, sample_rate};
  assign ge    = trial >= {1'b0, sample_rate};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_sh <= frequency_q4;
      rem    <= '0;
    end else if (cmd.step) begin
      div_sh <= {div_sh[FREQ_W-2:0], 1'b0};
      rem    <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      quo    <= {quo[PHASE_BITS-2:0], ge};
    end
  end

  // Phase accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (cmd.finish) begin
      phase <= phase + ((sample_rate == '0) ? '0 : quo);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sample_out <= neg_q ? -signed'(scaled) : signed'(scaled);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mpo_checker.sv =====
// Port-level checks for the multiwave phase oscillator, bound to the top level.
// Depends on mpo_pkg and multiwave_phase_oscillator.
`default_nettype none

module mpo_checker
  import mpo_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic signed [SAMPLE_W-1:0] sample_out
);

  // Rounding half up lets the sawtooth floor reach one code past the positive peak
  localparam logic signed [SAMPLE_W-1:0] OutMax = 16'sd26214;
  localparam logic signed [SAMPLE_W-1:0] OutMin = -16'sd26215;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("result beat dropped or changed while stalled");

  // Drop ready after a beat is taken: one beat in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while one is in work");

  // Scaled samples stay within 0.8 of full scale
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample_out <= OutMax) && (sample_out >= OutMin))
    else $error("sample outside the scaled range");

  // Come out of reset empty and ready
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind multiwave_phase_oscillator mpo_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out)
);

`default_nettype wire
